FILE: rtl/npbf_pkg.sv
// shared types, constants and tables for the note and pitch-bend to f-number block
package npbf_pkg;

  // field widths, then note handling
  localparam int unsigned NOTE_W      = 7;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned FNUM_W      = 10;
  localparam int unsigned BLOCK_W     = 4;
  localparam int unsigned SEMI_W      = 4;
  localparam int unsigned OCT_W       = 3;
  localparam int unsigned MAG_W       = 14;
  localparam int unsigned Q_W         = 9;
  localparam int unsigned IDX_W       = 6;
  localparam int unsigned RUNG_W      = 12;
  localparam int unsigned SLOPE_W     = 8;
  localparam int unsigned FRAC_W      = 8;
  localparam int unsigned V_W         = 13;

  localparam logic [NOTE_W-1:0] NOTE_OFS    = 7'd12;
  localparam logic [NOTE_W-1:0] NOTE_SPAN   = 7'd12;
  // n / 12 as (n * 43) >> 9, exact for n up to 115
  localparam logic [5:0]        DIV12_MUL   = 6'd43;
  localparam int unsigned       DIV12_SHIFT = 9;
  localparam logic [3:0]        OCT_MAX     = 4'd7;

  // bend period clamp and centre
  localparam logic [PERIOD_W-1:0] PER_MAX = 16'h3fff;
  localparam logic [MAG_W-1:0]    CENTRE  = 14'h2000;

  // x / 85 as (x * 24673) >> 21, exact for x up to 2^15
  localparam logic [14:0] DIV85_MUL   = 15'd24673;
  localparam int unsigned DIV85_SHIFT = 21;

  localparam logic [IDX_W-1:0] LADDER_ZERO = 6'd24;

  // renormalisation limits
  localparam logic signed [V_W-1:0] FN_BASE  = 13'sh0157;
  localparam logic signed [V_W-1:0] UP_LIM3  = 13'sh0ab8;
  localparam logic signed [V_W-1:0] UP_LIM2  = 13'sh055c;
  localparam logic signed [V_W-1:0] UP_LIM1  = 13'sh02ae;
  localparam logic signed [V_W-1:0] DN_LIM1  = 13'sh00ab;
  localparam logic signed [V_W-1:0] DN_LIM2  = 13'sh0055;
  localparam logic signed [V_W-1:0] DN_OFS3  = 13'sh002a;

  // every result lands in this window
  localparam logic [FNUM_W-1:0]  FNUM_LO   = 10'h157;
  localparam logic [FNUM_W-1:0]  FNUM_HI   = 10'h2af;
  localparam logic [BLOCK_W-1:0] BLOCK_TOP = 4'd10;

  typedef struct packed {
    logic [NOTE_W-1:0]   note;
    logic [PERIOD_W-1:0] period;
  } in_t;

  typedef struct packed {
    logic [FNUM_W-1:0]  fnum;
    logic [BLOCK_W-1:0] block;
  } out_t;

  // after note decode and period clamp
  typedef struct packed {
    logic              vld;
    logic [SEMI_W-1:0] semi;
    logic [OCT_W-1:0]  blk;
    logic              up;
    logic              zero;
    logic [MAG_W-1:0]  mag;
  } s1_t;

  // after the scale by 4/85
  typedef struct packed {
    logic              vld;
    logic [SEMI_W-1:0] semi;
    logic [OCT_W-1:0]  blk;
    logic              up;
    logic              zero;
    logic [Q_W-1:0]    q;
  } s2_t;

  // ladder rung and interpolation step
  typedef struct packed {
    logic              vld;
    logic [OCT_W-1:0]  blk;
    logic              up;
    logic              zero;
    logic [RUNG_W-1:0] rung;
    logic [FRAC_W-1:0] frac;
  } s3_t;

  // bent f-number before renormalisation
  typedef struct packed {
    logic                  vld;
    logic [OCT_W-1:0]      blk;
    logic                  up;
    logic                  zero;
    logic signed [V_W-1:0] v;
  } s4_t;

  // f-number ladder, rungs 24 to 35 are the semitone base values
  function automatic logic [RUNG_W-1:0] ladder_fnum(input logic [IDX_W-1:0] idx);
    logic [RUNG_W-1:0] f;
    case (idx)
      6'd0:  f = 12'h055;  6'd1:  f = 12'h05b;  6'd2:  f = 12'h060;  6'd3:  f = 12'h066;
      6'd4:  f = 12'h06c;  6'd5:  f = 12'h072;  6'd6:  f = 12'h079;  6'd7:  f = 12'h080;
      6'd8:  f = 12'h088;  6'd9:  f = 12'h090;  6'd10: f = 12'h099;  6'd11: f = 12'h0a2;
      6'd12: f = 12'h0ab;  6'd13: f = 12'h0b6;  6'd14: f = 12'h0c0;  6'd15: f = 12'h0cc;
      6'd16: f = 12'h0d8;  6'd17: f = 12'h0e5;  6'd18: f = 12'h0f3;  6'd19: f = 12'h101;
      6'd20: f = 12'h111;  6'd21: f = 12'h121;  6'd22: f = 12'h133;  6'd23: f = 12'h145;
      6'd24: f = 12'h157;  6'd25: f = 12'h16c;  6'd26: f = 12'h181;  6'd27: f = 12'h198;
      6'd28: f = 12'h1b1;  6'd29: f = 12'h1cb;  6'd30: f = 12'h1e6;  6'd31: f = 12'h203;
      6'd32: f = 12'h222;  6'd33: f = 12'h243;  6'd34: f = 12'h266;  6'd35: f = 12'h28a;
      6'd36: f = 12'h2ae;  6'd37: f = 12'h2d8;  6'd38: f = 12'h302;  6'd39: f = 12'h330;
      6'd40: f = 12'h362;  6'd41: f = 12'h396;  6'd42: f = 12'h3cc;  6'd43: f = 12'h406;
      6'd44: f = 12'h444;  6'd45: f = 12'h486;  6'd46: f = 12'h4cc;  6'd47: f = 12'h514;
      6'd48: f = 12'h55c;  6'd49: f = 12'h5b0;  6'd50: f = 12'h604;  6'd51: f = 12'h660;
      6'd52: f = 12'h6c4;  6'd53: f = 12'h72c;  6'd54: f = 12'h798;  6'd55: f = 12'h80c;
      6'd56: f = 12'h888;  6'd57: f = 12'h90c;  6'd58: f = 12'h998;  6'd59: f = 12'ha28;
      default: f = 12'ha28;
    endcase
    return f;
  endfunction

  // step to the next rung up from a semitone base
  function automatic logic [SLOPE_W-1:0] slope_up(input logic [SEMI_W-1:0] semi);
    logic [IDX_W-1:0] k;
    k = IDX_W'(semi) + LADDER_ZERO;
    return SLOPE_W'(ladder_fnum(k + 6'd1) - ladder_fnum(k));
  endfunction

  // step to the next rung down from a semitone base
  function automatic logic [SLOPE_W-1:0] slope_dn(input logic [SEMI_W-1:0] semi);
    logic [IDX_W-1:0] k;
    k = IDX_W'(semi) + LADDER_ZERO;
    return SLOPE_W'(ladder_fnum(k) - ladder_fnum(k - 6'd1));
  endfunction

endpackage

FILE: rtl/npbf_decode.sv
// stage one: note to semitone and octave, bend period clamp and distance from centre
module npbf_decode (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             adv,
  input  logic             in_vld,
  input  npbf_pkg::in_t    in_data,
  output npbf_pkg::s1_t    s1
);

  npbf_pkg::s1_t               s1_r;
  npbf_pkg::s1_t               s1_nxt;
  logic [npbf_pkg::NOTE_W-1:0] n;
  logic [12:0]                 oct_prod;
  logic [3:0]                  oct;
  logic [npbf_pkg::NOTE_W-1:0] rem;
  logic [npbf_pkg::MAG_W-1:0]  ax;

  always_comb begin
    n        = (in_data.note >= npbf_pkg::NOTE_OFS) ? in_data.note - npbf_pkg::NOTE_OFS : '0;
    oct_prod = 13'(n) * 13'(npbf_pkg::DIV12_MUL);
    oct      = oct_prod[npbf_pkg::DIV12_SHIFT +: 4];
    rem      = n - 7'(oct) * npbf_pkg::NOTE_SPAN;

    // negative reads as full down-bend, above range as full up-bend
    if (in_data.period[npbf_pkg::PERIOD_W-1]) begin
      ax = '0;
    end else if (in_data.period >= npbf_pkg::PER_MAX) begin
      ax = npbf_pkg::MAG_W'(npbf_pkg::PER_MAX);
    end else begin
      ax = in_data.period[npbf_pkg::MAG_W-1:0];
    end

    s1_nxt.vld  = in_vld;
    s1_nxt.semi = rem[npbf_pkg::SEMI_W-1:0];
    s1_nxt.blk  = (oct > npbf_pkg::OCT_MAX) ? npbf_pkg::OCT_MAX[npbf_pkg::OCT_W-1:0]
                                            : oct[npbf_pkg::OCT_W-1:0];
    s1_nxt.up   = ax > npbf_pkg::CENTRE;
    s1_nxt.zero = ax == npbf_pkg::CENTRE;
    s1_nxt.mag  = (ax > npbf_pkg::CENTRE) ? ax - npbf_pkg::CENTRE : npbf_pkg::CENTRE - ax;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
    end else if (adv) begin
      s1_r <= s1_nxt;
    end
  end

  assign s1 = s1_r;

endmodule

FILE: rtl/npbf_scale.sv
// stage two: bend distance times 4/85 by reciprocal multiply
module npbf_scale (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  npbf_pkg::s1_t s1,
  output npbf_pkg::s2_t s2
);

  npbf_pkg::s2_t s2_r;
  npbf_pkg::s2_t s2_nxt;
  logic [15:0]   x;
  logic [30:0]   prod;

  always_comb begin
    x    = {s1.mag, 2'b00};
    prod = 31'(x) * 31'(npbf_pkg::DIV85_MUL);

    s2_nxt.vld  = s1.vld;
    s2_nxt.semi = s1.semi;
    s2_nxt.blk  = s1.blk;
    s2_nxt.up   = s1.up;
    s2_nxt.zero = s1.zero;
    s2_nxt.q    = prod[npbf_pkg::DIV85_SHIFT +: npbf_pkg::Q_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_r <= '0;
    end else if (adv) begin
      s2_r <= s2_nxt;
    end
  end

  assign s2 = s2_r;

endmodule

FILE: rtl/npbf_interp.sv
// stage three: coarse ladder rung and fine interpolation step
module npbf_interp (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          adv,
  input  npbf_pkg::s2_t s2,
  output npbf_pkg::s3_t s3
);

  npbf_pkg::s3_t                s3_r;
  npbf_pkg::s3_t                s3_nxt;
  logic [4:0]                   coff;
  logic [3:0]                   fq;
  logic [npbf_pkg::IDX_W-1:0]   base_idx;
  logic [npbf_pkg::IDX_W-1:0]   idx;
  logic [npbf_pkg::SLOPE_W-1:0] slope;
  logic [11:0]                  fprod;

  always_comb begin
    coff     = s2.q[8:4];
    fq       = s2.q[3:0];
    // semitone base sits on rung semi + LADDER_ZERO (24)
    base_idx = npbf_pkg::IDX_W'(s2.semi) + npbf_pkg::LADDER_ZERO;
    idx      = s2.up ? base_idx + npbf_pkg::IDX_W'(coff) : base_idx - npbf_pkg::IDX_W'(coff);
    slope    = s2.up ? npbf_pkg::slope_up(s2.semi) : npbf_pkg::slope_dn(s2.semi);
    fprod    = 12'(slope) * 12'(fq);

    s3_nxt.vld  = s2.vld;
    s3_nxt.blk  = s2.blk;
    s3_nxt.up   = s2.up;
    s3_nxt.zero = s2.zero;
    s3_nxt.rung = npbf_pkg::ladder_fnum(idx);
    s3_nxt.frac = fprod[11:4];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_r <= '0;
    end else if (adv) begin
      s3_r <= s3_nxt;
    end
  end

  assign s3 = s3_r;

endmodule

FILE: rtl/npbf_norm.sv
// stages four and five: apply the bend, then fold the f-number back into range
module npbf_norm (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  npbf_pkg::s3_t  s3,
  output logic           out_vld,
  output npbf_pkg::out_t out_data
);

  npbf_pkg::s4_t                   s4_r;
  npbf_pkg::s4_t                   s4_nxt;
  logic                            out_vld_r;
  npbf_pkg::out_t                  out_data_r;
  npbf_pkg::out_t                  out_data_nxt;
  logic signed [npbf_pkg::V_W-1:0] vn;
  logic signed [4:0]               adj;
  logic signed [4:0]               blk_sum;

  always_comb begin
    s4_nxt.vld  = s3.vld;
    s4_nxt.blk  = s3.blk;
    s4_nxt.up   = s3.up;
    s4_nxt.zero = s3.zero;
    s4_nxt.v    = s3.up ? $signed(13'(s3.rung) + 13'(s3.frac))
                        : $signed(13'(s3.rung) - 13'(s3.frac));
  end

  always_comb begin
    vn  = s4_r.v;
    adj = '0;
    if (!s4_r.zero) begin
      if (s4_r.up) begin
        if (s4_r.v >= npbf_pkg::UP_LIM3) begin
          vn  = ((s4_r.v - npbf_pkg::UP_LIM3) >>> 3) + npbf_pkg::FN_BASE;
          adj = 5'sd3;
        end else if (s4_r.v >= npbf_pkg::UP_LIM2) begin
          vn  = ((s4_r.v - npbf_pkg::UP_LIM2) >>> 2) + npbf_pkg::FN_BASE;
          adj = 5'sd2;
        end else if (s4_r.v >= npbf_pkg::UP_LIM1) begin
          vn  = ((s4_r.v - npbf_pkg::UP_LIM1) >>> 1) + npbf_pkg::FN_BASE;
          adj = 5'sd1;
        end
      end else if (s4_r.v <= npbf_pkg::FN_BASE) begin
        if (s4_r.v > npbf_pkg::DN_LIM1) begin
          vn  = ((s4_r.v - npbf_pkg::DN_LIM1) <<< 1) + npbf_pkg::FN_BASE;
          adj = -5'sd1;
        end else if (s4_r.v > npbf_pkg::DN_LIM2) begin
          vn  = ((s4_r.v - npbf_pkg::DN_LIM2) <<< 2) + npbf_pkg::FN_BASE;
          adj = -5'sd2;
        end else begin
          vn  = ((s4_r.v - npbf_pkg::DN_OFS3) <<< 3) + npbf_pkg::FN_BASE;
          adj = -5'sd3;
        end
      end
    end
    blk_sum            = $signed({2'b00, s4_r.blk}) + adj;
    out_data_nxt.fnum  = vn[npbf_pkg::FNUM_W-1:0];
    out_data_nxt.block = blk_sum[4] ? '0 : blk_sum[npbf_pkg::BLOCK_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_r      <= '0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      s4_r      <= s4_nxt;
      out_vld_r <= s4_r.vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_vld  = out_vld_r;
  assign out_data = out_data_r;

endmodule

FILE: rtl/note_pitch_bend_to_fnum_block.sv
// top level: note number and bend period to bent f-number and octave block
// throughput: one beat per cycle while result beats are taken; the five register stages move together
// a held result beat freezes every stage and drops in_ready until it is taken
// reset (rst_n low, synchronous) empties the pipeline; no state is kept between beats
// stages: decode/clamp, multiply by 4/85, ladder lookup, bend add, renormalise
module note_pitch_bend_to_fnum_block (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  npbf_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output npbf_pkg::out_t out_data
);

  // pipeline advance: the result register is empty or its beat is being taken
  logic          adv;
  npbf_pkg::s1_t s1;
  npbf_pkg::s2_t s2;
  npbf_pkg::s3_t s3;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // semitone, octave, clamped period and direction of bend
  npbf_decode u_decode (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid),
    .in_data (in_data),
    .s1      (s1)
  );

  // distance from centre scaled to coarse and fine ladder steps
  npbf_scale u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .s1    (s1),
    .s2    (s2)
  );

  // target rung value and the interpolation step from the base slope
  npbf_interp u_interp (
    .clk   (clk),
    .rst_n (rst_n),
    .adv   (adv),
    .s2    (s2),
    .s3    (s3)
  );

  // bend applied, then shifted back into the base octave window
  npbf_norm u_norm (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .s3       (s3),
    .out_vld  (out_valid),
    .out_data (out_data)
  );

endmodule

FILE: rtl/npbf_checker.sv
// port checker for the note and pitch-bend to f-number block, with its bind
module npbf_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input npbf_pkg::out_t out_data
);

  // a result beat that is not taken stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat changed while stalled");

  // a stalled result holds the whole pipeline, so no input is taken
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result stalled");

  // renormalised results lie in the base octave window
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.fnum >= npbf_pkg::FNUM_LO && out_data.fnum <= npbf_pkg::FNUM_HI
                  && out_data.block <= npbf_pkg::BLOCK_TOP)
    else $error("result out of range");

  // reset empties the pipeline
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind note_pitch_bend_to_fnum_block npbf_checker u_npbf_checker (.*);

FILE: bench/tb.sv
// self-checking bench for the note and pitch-bend to f-number block
`timescale 1ns / 1ps

module tb;

  typedef struct packed {
    npbf_pkg::in_t  src;
    npbf_pkg::out_t res;
  } bend_case_t;

  class bend_scoreboard;
    int unsigned semi_tab[12];
    int unsigned ladder_tab[60];
    int unsigned rung_tab[16];
    bend_case_t  fnum_expected_q[$];
    int          mismatches;

    function new();
      semi_tab   = '{'h157, 'h16c, 'h181, 'h198, 'h1b1, 'h1cb,
                     'h1e6, 'h203, 'h222, 'h243, 'h266, 'h28a};
      ladder_tab = '{'h055, 'h05b, 'h060, 'h066, 'h06c, 'h072, 'h079, 'h080,
                     'h088, 'h090, 'h099, 'h0a2, 'h0ab, 'h0b6, 'h0c0, 'h0cc,
                     'h0d8, 'h0e5, 'h0f3, 'h101, 'h111, 'h121, 'h133, 'h145,
                     'h157, 'h16c, 'h181, 'h198, 'h1b1, 'h1cb, 'h1e6, 'h203,
                     'h222, 'h243, 'h266, 'h28a, 'h2ae, 'h2d8, 'h302, 'h330,
                     'h362, 'h396, 'h3cc, 'h406, 'h444, 'h486, 'h4cc, 'h514,
                     'h55c, 'h5b0, 'h604, 'h660, 'h6c4, 'h72c, 'h798, 'h80c,
                     'h888, 'h90c, 'h998, 'ha28};
      rung_tab   = '{0, 1, 2, 3, 4, 5, 0, 6, 7, 0, 8, 9, 0, 10, 0, 11};
      mismatches = 0;
    endfunction

    // ladder entry i rungs above rung 24 (the first semitone base), clamped to the table ends
    function int ladder_at(input int i);
      int k;
      k = i + 24;
      if (k < 0) k = 0;
      if (k > 59) k = 59;
      return int'(ladder_tab[k]);
    endfunction

    function npbf_pkg::out_t bend_fnum(input npbf_pkg::in_t item);
      int             n, base, blk, ax, off, r, mag, q, coff, fq, coarse, slope, v;
      npbf_pkg::out_t res;
      n = int'(item.note) - 12;
      if (n < 0) n = 0;
      base = int'(semi_tab[n % 12]);
      blk  = n / 12;
      if (blk > 7) blk = 7;

      // negative periods act as the full down-bend, large ones as the full up-bend
      ax = item.period[15] ? 0 : int'(item.period);
      if (ax >= 'h3fff) ax = 'h3fff;
      off = ax - 'h2000;

      v = base;
      if (off != 0) begin
        r    = int'(rung_tab[((base - 'h157) / 20) & 'hf]);
        mag  = (off > 0) ? off : -off;
        q    = (mag * 4) / 'h55;
        coff = ((q >>> 3) & 'hfe) / 2;
        fq   = q & 'h0f;
        if (off > 0) begin
          coarse = ladder_at(r + coff) - ladder_at(r);
          slope  = ladder_at(r + 1) - ladder_at(r);
          v = base + coarse + ((slope * fq) >>> 4);
          if (v >= 'hab8) begin
            v = ((v - 'hab8) >>> 3) + 'h157; blk += 3;
          end else if (v >= 'h55c) begin
            v = ((v - 'h55c) >>> 2) + 'h157; blk += 2;
          end else if (v >= 'h2ae) begin
            v = ((v - 'h2ae) >>> 1) + 'h157; blk += 1;
          end
        end else begin
          coarse = ladder_at(r) - ladder_at(r - coff);
          slope  = ladder_at(r) - ladder_at(r - 1);
          v = base - (coarse + ((slope * fq) >>> 4));
          if (v <= 'h157) begin
            if (v > 'hab) begin
              v = (v - 'hab) * 2 + 'h157; blk -= 1;
            end else if (v > 'h55) begin
              v = (v - 'h55) * 4 + 'h157; blk -= 2;
            end else begin
              v = (v - 'h2a) * 8 + 'h157; blk -= 3;
            end
          end
        end
      end

      if (blk < 0) blk = 0;
      res.fnum  = v[npbf_pkg::FNUM_W-1:0];
      res.block = blk[npbf_pkg::BLOCK_W-1:0];
      return res;
    endfunction

    function void note_request(input npbf_pkg::in_t item);
      bend_case_t c;
      c.src = item;
      c.res = bend_fnum(item);
      fnum_expected_q.push_back(c);
    endfunction

    function void check_result(input npbf_pkg::out_t got);
      bend_case_t c;
      if (fnum_expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result beat: fnum=%h block=%0d", got.fnum, got.block);
        return;
      end
      c = fnum_expected_q.pop_front();
      if (got.fnum !== c.res.fnum || got.block !== c.res.block) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch note=%0d period=%h: expected fnum=%h block=%0d, got fnum=%h block=%0d",
                   c.src.note, c.src.period, c.res.fnum, c.res.block, got.fnum, got.block);
      end
    endfunction

    function int outstanding();
      return fnum_expected_q.size();
    endfunction
  endclass

  logic           clk;
  logic           rst_n;
  logic           in_valid;
  logic           in_ready;
  npbf_pkg::in_t  in_data;
  logic           out_valid;
  logic           out_ready;
  npbf_pkg::out_t out_data;

  // set for the tail of the run, where neither side idles
  bit calm;

  bend_scoreboard sb;

  note_pitch_bend_to_fnum_block dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

  // result side: every accepted beat is checked at the rising edge
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_data);
  end

  // result side back-pressure: bursts of ready and stall, always ready once calm
  initial begin
    int  n;
    bit  lvl;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (calm) begin
        @(negedge clk);
        out_ready = 1'b1;
      end else begin
        n   = $urandom_range(1, 8);
        lvl = ($urandom_range(0, 2) != 0);
        repeat (n) begin
          @(negedge clk);
          out_ready = lvl;
        end
      end
    end
  end

  // present one beat and hold it until the block takes it
  task automatic send_beat(input npbf_pkg::in_t item);
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = item;
    do @(posedge clk); while (!in_ready);
    sb.note_request(item);
  endtask

  // sender gap with in_valid low; n sets its length
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
  endtask

  // hold off until every expected result has come back
  task automatic drain_results();
    @(negedge clk);
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(negedge clk);
  endtask

  // random beat with the period weighted towards the interesting regions
  function automatic npbf_pkg::in_t random_beat();
    npbf_pkg::in_t item;
    int            p;
    item.note = npbf_pkg::NOTE_W'($urandom_range(0, 127));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: p = $urandom_range(0, 'h3fff);
      4, 5:       p = 'h2000 + $urandom_range(0, 'h800) - 'h400;
      6:          p = $urandom;
      7:          p = 'h8000 | $urandom_range(0, 'h7fff);
      8:          p = $urandom_range('h4000, 'h7fff);
      default: begin
        case ($urandom_range(0, 4))
          0: p = 'h0000;
          1: p = 'h3fff;
          2: p = 'h2000;
          3: p = 'h1fff;
          default: p = 'h2001;
        endcase
      end
    endcase
    item.period = p[npbf_pkg::PERIOD_W-1:0];
    return item;
  endfunction

  initial begin
    logic [npbf_pkg::NOTE_W-1:0]   d_note[24];
    logic [npbf_pkg::PERIOD_W-1:0] d_per[24];
    npbf_pkg::in_t                 item;

    sb        = new();
    calm      = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;

    // directed corners: centre pass-through, full bends both ways, clamps,
    // one-step bends, floor of the block at zero and the top-note cap
    d_note = '{7'd0,   7'd127, 7'd12,  7'd127, 7'd60,  7'd60,
               7'd60,  7'd60,  7'd60,  7'd60,  7'd71,  7'd71,
               7'd12,  7'd23,  7'd66,  7'd66,  7'd11,  7'd100,
               7'd100, 7'd45,  7'd45,  7'd127, 7'd0,   7'd127};
    d_per  = '{16'h2000, 16'h2000, 16'h0000, 16'h3fff, 16'h8000, 16'hffff,
               16'h4000, 16'h7fff, 16'h2001, 16'h1fff, 16'h3fff, 16'h0000,
               16'h3fff, 16'h0000, 16'h2400, 16'h1c00, 16'h2155, 16'h3000,
               16'h1000, 16'h2aaa, 16'h1555, 16'h0000, 16'hffff, 16'hffff};

    // synchronous reset asserted at the start, then released on a falling edge
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    foreach (d_note[i]) begin
      item.note   = d_note[i];
      item.period = d_per[i];
      send_beat(item);
      if ($urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 8));
    end

    // let the pipeline run dry once before the random part
    drain_results();

    for (int i = 0; i < 600; i++) begin
      if (i == 300) drain_results();
      // last stretch runs with no gaps on either side
      if (i == 520) calm = 1'b1;
      if (!calm && $urandom_range(0, 3) == 0) idle_cycles($urandom_range(1, 8));
      send_beat(random_beat());
    end

    @(negedge clk);
    in_valid = 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    // keep clocking so that any stray result beat is caught
    repeat (20) @(posedge clk);

    if (sb.mismatches == 0 && sb.outstanding() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

FILE: note_pitch_bend_to_fnum_block.f
rtl/npbf_pkg.sv
rtl/npbf_decode.sv
rtl/npbf_scale.sv
rtl/npbf_interp.sv
rtl/npbf_norm.sv
rtl/note_pitch_bend_to_fnum_block.sv
rtl/npbf_checker.sv
bench/tb.sv
